// ===== rtl/core/pcd_pkg.sv =====
// Shared types and constants for the point to cylinder distance unit.
package pcd_pkg;

    localparam int CoordW  = 32;
    localparam int DiffW   = 33;
    localparam int ProdW   = 65;
    localparam int MagW    = 64;
    localparam int RemW    = 132;
    localparam int TW      = 97;
    localparam int RootW   = 33;
    localparam int RootTop = 32;

    typedef enum logic [2:0] {
        REG_ROOT_X = 3'd0,
        REG_ROOT_Y = 3'd1,
        REG_ROOT_Z = 3'd2,
        REG_AXIS_X = 3'd3,
        REG_AXIS_Y = 3'd4,
        REG_AXIS_Z = 3'd5,
        REG_RADIUS = 3'd6,
        REG_NONE   = 3'd7
    } cfg_reg_t;

    localparam logic [CoordW-1:0] AxisZReset = 32'd65536;

    // Square root recurrence state: rem = c2 - r^2*a2, t = r*a2.
    typedef struct packed {
        logic [RemW-1:0]  rem;
        logic [TW-1:0]    t;
        logic [RootW-1:0] r;
        logic [MagW-1:0]  a2;
        logic             degen;
    } pcd_root_t;

endpackage

// ===== rtl/core/pcd_root_stage.sv =====
// One registered step of the bit-serial square root, resolving one root bit.
module pcd_root_stage
    import pcd_pkg::*;
#(
    parameter int BIT = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_vld,
    input  pcd_root_t in_data,
    output logic      out_vld,
    output pcd_root_t out_data
);

    logic            vld_reg;
    pcd_root_t       data_reg;
    pcd_root_t       data_next;
    logic [RemW-1:0] delta;
    logic            capped;
    logic            take;

    always_comb
    begin
        delta = ((RemW'(in_data.t) << 1) + (RemW'(in_data.a2) << BIT)) << BIT;
        capped = (BIT != RootTop) ? in_data.r[RootTop] : 1'b0;
        take = !capped && (delta <= in_data.rem);
        data_next = in_data;
        if (take)
        begin
            data_next.rem = in_data.rem - delta;
            data_next.t = in_data.t + (TW'(in_data.a2) << BIT);
            data_next.r = in_data.r | (RootW'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule

// ===== rtl/core/point_to_cylinder_distance_unit.sv =====
// Point to cylinder distance: top level with config registers and the full pipeline.
// Takes one Q16.16 point per cycle while the pipeline advances, and returns
// floor(|(p - root) x axis| / |axis|) minus the radius, saturated, or zero with
// degenerate_axis set when the axis is all zero. The stages are one difference stage,
// one cross product stage, one magnitude stage, one partial square stage, one sum
// stage, 33 square root stages (one root bit each) and the output register. The whole
// pipeline advances together whenever the output register is empty or being taken.
module point_to_cylinder_distance_unit
    import pcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [CoordW-1:0]  cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] surface_distance,
    output logic               degenerate_axis
);

    localparam int NumRoot = RootTop + 1;

    logic signed [CoordW-1:0] root_x_reg, root_y_reg, root_z_reg;
    logic signed [CoordW-1:0] axis_x_reg, axis_y_reg, axis_z_reg;
    logic signed [CoordW-1:0] radius_reg;

    logic adv;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_x_reg <= '0;
            root_y_reg <= '0;
            root_z_reg <= '0;
            axis_x_reg <= '0;
            axis_y_reg <= '0;
            axis_z_reg <= AxisZReset;
            radius_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ROOT_X: root_x_reg <= cfg_data;
                REG_ROOT_Y: root_y_reg <= cfg_data;
                REG_ROOT_Z: root_z_reg <= cfg_data;
                REG_AXIS_X: axis_x_reg <= cfg_data;
                REG_AXIS_Y: axis_y_reg <= cfg_data;
                REG_AXIS_Z: axis_z_reg <= cfg_data;
                REG_RADIUS: radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits of the front stages
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // stage 1: offset from root
    logic signed [DiffW-1:0] d_reg [3];
    // stage 2: cross product terms and axis norm
    logic signed [ProdW-1:0] prod_reg [6];
    logic [MagW-1:0]         a2_s2_reg;
    // stage 3: cross component magnitudes
    logic [MagW-1:0]         m_reg [3];
    logic [MagW-1:0]         a2_s3_reg;
    logic                    degen_s3_reg;
    // stage 4: partial squares
    logic [MagW-1:0]         hh_reg [3];
    logic [MagW-1:0]         hl_reg [3];
    logic [MagW-1:0]         ll_reg [3];
    logic [MagW-1:0]         a2_s4_reg;
    logic                    degen_s4_reg;
    // stage 5: squared cross norm
    pcd_root_t               root_in_reg;

    logic signed [MagW-1:0]  ax_sq, ay_sq, az_sq;
    logic signed [ProdW:0]   cdiff [3];
    logic [MagW-1:0]         m_next [3];
    logic [RemW-1:0]         c2_next;

    always_comb
    begin
        ax_sq = axis_x_reg * axis_x_reg;
        ay_sq = axis_y_reg * axis_y_reg;
        az_sq = axis_z_reg * axis_z_reg;
        for (int i = 0; i < 3; i++)
        begin
            cdiff[i] = (ProdW+1)'(prod_reg[2*i]) - (ProdW+1)'(prod_reg[2*i+1]);
            m_next[i] = cdiff[i][ProdW] ? MagW'(-cdiff[i]) : MagW'(cdiff[i]);
        end
        c2_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            c2_next = c2_next + (RemW'(hh_reg[i]) << 64) + (RemW'(hl_reg[i]) << 33)
                + RemW'(ll_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0] <= DiffW'(point_x) - DiffW'(root_x_reg);
            d_reg[1] <= DiffW'(point_y) - DiffW'(root_y_reg);
            d_reg[2] <= DiffW'(point_z) - DiffW'(root_z_reg);

            prod_reg[0] <= d_reg[1] * axis_z_reg;
            prod_reg[1] <= d_reg[2] * axis_y_reg;
            prod_reg[2] <= d_reg[2] * axis_x_reg;
            prod_reg[3] <= d_reg[0] * axis_z_reg;
            prod_reg[4] <= d_reg[0] * axis_y_reg;
            prod_reg[5] <= d_reg[1] * axis_x_reg;
            a2_s2_reg <= MagW'(ax_sq) + MagW'(ay_sq) + MagW'(az_sq);

            for (int i = 0; i < 3; i++)
            begin
                m_reg[i] <= m_next[i];
            end
            a2_s3_reg    <= a2_s2_reg;
            degen_s3_reg <= (a2_s2_reg == '0);

            for (int i = 0; i < 3; i++)
            begin
                hh_reg[i] <= m_reg[i][63:32] * m_reg[i][63:32];
                hl_reg[i] <= m_reg[i][63:32] * m_reg[i][31:0];
                ll_reg[i] <= m_reg[i][31:0] * m_reg[i][31:0];
            end
            a2_s4_reg    <= a2_s3_reg;
            degen_s4_reg <= degen_s3_reg;

            root_in_reg.rem   <= c2_next;
            root_in_reg.t     <= '0;
            root_in_reg.r     <= '0;
            root_in_reg.a2    <= a2_s4_reg;
            root_in_reg.degen <= degen_s4_reg;
        end
    end

    logic      root_vld  [NumRoot+1];
    pcd_root_t root_data [NumRoot+1];

    assign root_vld[0]  = v5_reg;
    assign root_data[0] = root_in_reg;

    for (genvar g = 0; g < NumRoot; g++)
    begin : g_root
        pcd_root_stage #(
            .BIT(RootTop - g)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_vld  (root_vld[g]),
            .in_data (root_data[g]),
            .out_vld (root_vld[g+1]),
            .out_data(root_data[g+1])
        );
    end

    // output: subtract radius, saturate, force zero for a degenerate axis
    logic                    out_vld_reg;
    logic signed [31:0]      dist_reg;
    logic                    degen_reg;
    logic signed [RootW+1:0] res;
    logic signed [31:0]      dist_next;
    pcd_root_t               last;

    always_comb
    begin
        last = root_data[NumRoot];
        res = $signed({2'b00, last.r}) - (RootW+2)'(radius_reg);
        if (res > (RootW+2)'(32'sh7FFF_FFFF))
        begin
            dist_next = 32'sh7FFF_FFFF;
        end
        else if (res < -(RootW+2)'(35'sh8000_0000))
        begin
            dist_next = 32'sh8000_0000;
        end
        else
        begin
            dist_next = res[31:0];
        end
        if (last.degen)
        begin
            dist_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= root_vld[NumRoot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg  <= dist_next;
            degen_reg <= last.degen;
        end
    end

    assign out_valid        = out_vld_reg;
    assign surface_distance = dist_reg;
    assign degenerate_axis  = degen_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate_axis |-> surface_distance == '0)
        else $error("degenerate item with nonzero distance");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow pipeline advance");

    a_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate_axis && radius_reg == '0 |-> !surface_distance[31])
        else $error("negative distance with zero radius");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(root_vld[NumRoot]) && $stable(v5_reg))
        else $error("pipeline moved during stall");

endmodule
